>>> src/mnfc_pkg.sv
// Shared constants, types and helper functions for the magic number file classifier.
// Used by magic_number_file_classifier_core and its checker; depends on nothing else.

package mnfc_pkg;

    localparam int ENTRIES     = 8;
    localparam int MAX_MAGIC   = 8;
    localparam int SNIFF_BYTES = 1024;

    localparam int IDX_W       = 3;
    localparam int LEN_W       = 4;
    localparam int CNT_W       = 4;
    localparam int MAGIC_W     = 64;
    localparam int POS_W       = $clog2(SNIFF_BYTES + 1);
    localparam int MSEL_W      = (MAX_MAGIC > 1) ? $clog2(MAX_MAGIC) : 1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_BYTE  = 1'b1;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;

    typedef logic [MAGIC_W-1:0] magic_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [POS_W-1:0]   pos_t;

    function automatic logic is_text_byte(input logic [7:0] b);
        return (b == CHAR_LF) || (b == CHAR_CR) || (b == CHAR_TAB) ||
               ((b >= CHAR_SPACE) && (b <= CHAR_TILDE));
    endfunction

endpackage

>>> src/magic_number_file_classifier_core.sv
// Top level of the magic number file classifier: format table, prefix tracking and result.
// Depends on mnfc_pkg for sizes, request codes and the text byte test.
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_valid/s_ready    load word or file byte word
//  m_*      out        m_valid/m_ready    found, match_index, by_magic, is_binary
//  cfg_*    in         cfg_wr_en          entry_count
//
// One word is accepted per cycle while s_ready is high; a result appears in the cycle after its last word.
// The path per word is the parallel byte compare of all entries and the priority pick.
// Reset clears the stream state, the entry count and the result valid flag; the table
// and result word hold no defined value until written. A stalled result blocks new
// words only when the result register is full and not being taken.

module magic_number_file_classifier_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [2:0]  s_entry_index,
    input  logic [63:0] s_entry_magic,
    input  logic [3:0]  s_entry_magic_len,
    input  logic        s_entry_is_binary,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_last_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [2:0]  m_match_index,
    output logic        m_by_magic,
    output logic        m_is_binary
);

    localparam int ENTRIES = mnfc_pkg::ENTRIES;
    localparam int POS_W   = mnfc_pkg::POS_W;
    localparam int MSEL_W  = mnfc_pkg::MSEL_W;
    localparam int LEN_W   = mnfc_pkg::LEN_W;
    localparam int IDX_W   = mnfc_pkg::IDX_W;
    localparam int CNT_W   = mnfc_pkg::CNT_W;

    mnfc_pkg::magic_t table_magic_reg [ENTRIES];
    mnfc_pkg::len_t   table_len_reg   [ENTRIES];
    logic [ENTRIES-1:0] table_binary_reg;

    logic [ENTRIES-1:0] match_reg, match_next;
    logic               text_reg, text_next;
    mnfc_pkg::pos_t     pos_reg, pos_next;
    logic [CNT_W-1:0]   count_reg;

    logic               out_valid_reg;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   index_reg, index_next;
    logic               by_magic_reg, by_magic_next;
    logic               binary_reg, binary_next;

    logic               accept;
    logic               byte_accept;
    logic               load_accept;
    logic               result_accept;
    logic               take_byte;
    logic [MSEL_W-1:0]  byte_sel;
    logic [ENTRIES-1:0] magic_hit;
    logic [ENTRIES-1:0] fallback_hit;
    logic [LEN_W-1:0]   load_len;

    assign s_ready       = !out_valid_reg || m_ready;
    assign accept        = s_valid && s_ready;
    assign load_accept   = accept && (s_req_type == mnfc_pkg::REQ_LOAD);
    assign byte_accept   = accept && (s_req_type == mnfc_pkg::REQ_BYTE);
    assign result_accept = byte_accept && s_last_byte;
    assign take_byte     = s_byte_present && (pos_reg < POS_W'(mnfc_pkg::SNIFF_BYTES));
    assign byte_sel      = pos_reg[MSEL_W-1:0];

    assign load_len = (s_entry_magic_len > LEN_W'(mnfc_pkg::MAX_MAGIC)) ?
                      LEN_W'(mnfc_pkg::MAX_MAGIC) : s_entry_magic_len;

    // Stream state after this byte, then the result drawn from it.
    always_comb begin
        match_next = match_reg;
        text_next  = text_reg;
        pos_next   = pos_reg;
        if (take_byte) begin
            if (pos_reg < POS_W'(mnfc_pkg::MAX_MAGIC)) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if ((POS_W'(table_len_reg[i]) > pos_reg) &&
                        (table_magic_reg[i][{byte_sel, 3'b000} +: 8] != s_data_byte)) begin
                        match_next[i] = 1'b0;
                    end
                end
            end
            if (!mnfc_pkg::is_text_byte(s_data_byte)) begin
                text_next = 1'b0;
            end
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            magic_hit[i]    = (CNT_W'(i) < count_reg) && (table_len_reg[i] != '0) &&
                              match_next[i] && (POS_W'(table_len_reg[i]) <= pos_next);
            fallback_hit[i] = (CNT_W'(i) < count_reg) && (table_len_reg[i] == '0) &&
                              (table_binary_reg[i] == !text_next);
        end
    end

    always_comb begin
        found_next    = 1'b0;
        index_next    = '0;
        by_magic_next = 1'b0;
        binary_next   = !text_next;
        if (|magic_hit) begin
            found_next    = 1'b1;
            by_magic_next = 1'b1;
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (magic_hit[i]) begin
                    index_next = IDX_W'(i);
                end
            end
        end else if (|fallback_hit) begin
            found_next = 1'b1;
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (fallback_hit[i]) begin
                    index_next = IDX_W'(i);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg     <= '1;
            text_reg      <= 1'b1;
            pos_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
            if (result_accept) begin
                match_reg <= '1;
                text_reg  <= 1'b1;
                pos_reg   <= '0;
            end else if (byte_accept) begin
                match_reg <= match_next;
                text_reg  <= text_next;
                pos_reg   <= pos_next;
            end
            if (result_accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_accept) begin
            table_magic_reg[s_entry_index]  <= s_entry_magic;
            table_len_reg[s_entry_index]    <= load_len;
            table_binary_reg[s_entry_index] <= s_entry_is_binary;
        end
        if (result_accept) begin
            found_reg    <= found_next;
            index_reg    <= index_next;
            by_magic_reg <= by_magic_next;
            binary_reg   <= binary_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_found       = found_reg;
    assign m_match_index = index_reg;
    assign m_by_magic    = by_magic_reg;
    assign m_is_binary   = binary_reg;

endmodule

>>> src/mnfc_checker.sv
// Port-level checker for magic_number_file_classifier_core, bound to the top level.
// Depends on mnfc_pkg for the request codes.

module mnfc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_req_type,
    input logic        s_last_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_found,
    input logic [2:0]  m_match_index,
    input logic        m_by_magic,
    input logic        m_is_binary
);

    // A result that waits keeps its word unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_found) &&
        $stable(m_match_index) && $stable(m_by_magic) && $stable(m_is_binary)))
        else $error("result word changed while stalled");

    // The input side is held back only by a full, stalled result register.
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow the result register");

    // A load word or a non-final byte word never brings a result.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready &&
        ((s_req_type == mnfc_pkg::REQ_LOAD) || !s_last_byte)) |=> !m_valid)
        else $error("result without a final byte word");

    // A final byte word always brings a result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_req_type == mnfc_pkg::REQ_BYTE) && s_last_byte)
        |=> m_valid)
        else $error("final byte word gave no result");

    // No selection reports index zero and no prefix match.
    a_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> ((m_match_index == 3'd0) && !m_by_magic))
        else $error("empty result carries an index or a prefix match");

endmodule

bind magic_number_file_classifier_core mnfc_checker u_mnfc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_req_type    (s_req_type),
    .s_last_byte   (s_last_byte),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_found       (m_found),
    .m_match_index (m_match_index),
    .m_by_magic    (m_by_magic),
    .m_is_binary   (m_is_binary)
);
